### hdl/efa_pkg.sv
// ----------------------------------------------------------------------------
// efa_pkg
// Types and constants shared by the ECN-fraction alpha estimator.
// ----------------------------------------------------------------------------
package efa_pkg;

  localparam int unsigned SEQ_W   = 32;
  localparam int unsigned ALPHA_W = 11;
  localparam int unsigned GAIN_W  = 4;
  localparam int unsigned MSS_W   = 16;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned SHIFT_W = 5;

  localparam logic [ALPHA_W-1:0] ALPHA_FULL = 11'd1024;
  localparam logic [SHIFT_W-1:0] FRAC_BITS  = 5'd10;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_ACK   = 2'd1,
    KIND_LOSS  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_GAIN_SHIFT    = 2'd0,
    REG_INITIAL_ALPHA = 2'd1,
    REG_FORCE_MAX     = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_ACCUM,
    ST_PREP,
    ST_DIV,
    ST_ALPHA,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [SEQ_W-1:0] dividend;
    logic [SEQ_W-1:0] divisor;
  } div_ctrl_t;

  typedef struct packed {
    logic             done;
    logic [SEQ_W-1:0] quotient;
  } div_stat_t;

endpackage

### hdl/efa_ifs.sv
// ----------------------------------------------------------------------------
// efa_ifs
// Request, result and configuration channels of the alpha estimator.
// ----------------------------------------------------------------------------
interface efa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] acked_seq;
  logic [31:0] next_send_seq;
  logic [15:0] recv_mss;
  logic        ece_flag;
  logic        window_update_flag;

  modport source (output valid, kind, acked_seq, next_send_seq, recv_mss,
                  ece_flag, window_update_flag, input ready);
  modport sink (input valid, kind, acked_seq, next_send_seq, recv_mss,
                ece_flag, window_update_flag, output ready);
endinterface

interface efa_res_if;
  logic        valid;
  logic        ready;
  logic [10:0] alpha;
  logic        window_closed;

  modport source (output valid, alpha, window_closed, input ready);
  modport sink (input valid, alpha, window_closed, output ready);
endinterface

interface efa_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/efa_divider.sv
// ----------------------------------------------------------------------------
// efa_divider
// Radix-2 restoring divider: the dividend shifts in one bit per cycle and
// one quotient bit shifts out per cycle.
// ----------------------------------------------------------------------------
module efa_divider (
  input  logic              clk,
  input  logic              rst,
  input  efa_pkg::div_ctrl_t ctrl,
  output efa_pkg::div_stat_t stat
);
  import efa_pkg::*;

  logic [SEQ_W-1:0] rem;
  logic [SEQ_W-1:0] quo;
  logic [SEQ_W-1:0] dsr;
  logic [4:0]       cnt;
  logic             busy;
  logic             done;
  logic [SEQ_W:0]   shifted;
  logic [SEQ_W:0]   trial;

  assign shifted = {rem, quo[SEQ_W-1]};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= 5'd31;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= '0;
      quo <= ctrl.dividend;
      dsr <= ctrl.divisor;
    end else if (busy) begin
      if (!trial[SEQ_W]) begin
        rem <= trial[SEQ_W-1:0];
        quo <= {quo[SEQ_W-2:0], 1'b1};
      end else begin
        rem <= shifted[SEQ_W-1:0];
        quo <= {quo[SEQ_W-2:0], 1'b0};
      end
    end
  end

  assign stat.done     = done;
  assign stat.quotient = quo;

endmodule

### hdl/ecn_fraction_alpha_estimator_unit.sv
// ----------------------------------------------------------------------------
// ecn_fraction_alpha_estimator_unit
// Per-connection DCTCP alpha estimator with a bit-serial window divider.
// ----------------------------------------------------------------------------
// One request is in work at a time. A start, loss or unused request passes
// through the count state to the done state, an ack that leaves the window
// open through the count and accumulate states, and an ack that closes the
// window also through the prep, divide and alpha states, where the radix-2
// divider forms marked/total one quotient bit per cycle. The next request is
// taken in the cycle after the result is registered; the result register
// holds while the sink stalls. Configuration writes are taken in every cycle.
module ecn_fraction_alpha_estimator_unit (
  input logic clk,
  input logic rst,
  efa_req_if.sink   request,
  efa_res_if.source result,
  efa_cfg_if.sink   cfg
);
  import efa_pkg::*;

  logic [GAIN_W-1:0]  gain_shift;
  logic [ALPHA_W-1:0] initial_alpha;
  logic               force_max_on_loss;

  logic [ALPHA_W-1:0] alpha_value;
  logic [SEQ_W-1:0]   marked_bytes;
  logic [SEQ_W-1:0]   total_bytes;
  logic [SEQ_W-1:0]   last_acked_seq;
  logic [SEQ_W-1:0]   window_end_seq;

  kind_t              item_kind;
  logic [SEQ_W-1:0]   item_acked;
  logic [SEQ_W-1:0]   item_next;
  logic [MSS_W-1:0]   item_mss;
  logic               item_ece;
  logic               item_wupd;

  logic [SEQ_W-1:0]   count;
  logic               win_end;
  logic               closed;
  logic [ALPHA_W-1:0] alpha_dec;
  logic [SEQ_W-1:0]   dividend;
  logic [SEQ_W-1:0]   divisor;

  logic               res_valid;
  logic [ALPHA_W-1:0] res_alpha;
  logic               res_closed;

  state_t             state;
  state_t             state_next;

  logic               accept;
  logic               load_out;
  logic [SEQ_W-1:0]   count_raw;
  logic [SEQ_W-1:0]   end_diff;
  logic [SHIFT_W-1:0] up;
  logic [SEQ_W-1:0]   alpha_sum;

  div_ctrl_t          div_ctrl;
  div_stat_t          div_stat;

  efa_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .ctrl (div_ctrl),
    .stat (div_stat)
  );

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_shift        <= 4'd4;
      initial_alpha     <= ALPHA_FULL;
      force_max_on_loss <= 1'b0;
    end else if (cfg.valid) begin
      case (reg_index_t'(cfg.index))
        REG_GAIN_SHIFT:    gain_shift        <= cfg.data[GAIN_W-1:0];
        REG_INITIAL_ALPHA: initial_alpha     <= cfg.data;
        REG_FORCE_MAX:     force_max_on_loss <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign count_raw = item_acked - last_acked_seq;
  assign end_diff  = item_acked - window_end_seq;
  assign up        = FRAC_BITS - {1'b0, gain_shift};
  assign alpha_sum = {{(SEQ_W-ALPHA_W){1'b0}}, alpha_dec} + div_stat.quotient;
  assign dividend  = marked_bytes << up;
  assign divisor   = (total_bytes == '0) ? {{(SEQ_W-1){1'b0}}, 1'b1} : total_bytes;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (request.valid) state_next = ST_COUNT;
      ST_COUNT: state_next = (item_kind == KIND_ACK) ? ST_ACCUM : ST_DONE;
      ST_ACCUM: state_next = win_end ? ST_PREP : ST_DONE;
      ST_PREP:  state_next = ST_DIV;
      ST_DIV:   if (div_stat.done) state_next = ST_ALPHA;
      ST_ALPHA: state_next = ST_DONE;
      ST_DONE:  if (!res_valid || result.ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    request.ready     = (state == ST_IDLE);
    load_out          = (state == ST_DONE) && (!res_valid || result.ready);
    div_ctrl.start    = (state == ST_PREP);
    div_ctrl.dividend = dividend;
    div_ctrl.divisor  = divisor;
  end

  assign accept = request.valid && request.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      res_valid      <= 1'b0;
      alpha_value    <= ALPHA_FULL;
      marked_bytes   <= '0;
      total_bytes    <= '0;
      last_acked_seq <= '0;
      window_end_seq <= '0;
    end else begin
      state <= state_next;
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_COUNT: begin
          if (item_kind == KIND_START) begin
            alpha_value    <= (initial_alpha > ALPHA_FULL) ? ALPHA_FULL : initial_alpha;
            last_acked_seq <= item_acked;
            window_end_seq <= item_next;
            marked_bytes   <= '0;
            total_bytes    <= '0;
          end else if (item_kind == KIND_LOSS && force_max_on_loss) begin
            alpha_value <= ALPHA_FULL;
          end
        end
        ST_ACCUM: begin
          if (count != '0) begin
            total_bytes    <= total_bytes + count;
            last_acked_seq <= item_acked;
            if (item_ece) begin
              marked_bytes <= marked_bytes + count;
            end
          end
        end
        ST_ALPHA: begin
          alpha_value    <= (alpha_sum > {{(SEQ_W-ALPHA_W){1'b0}}, ALPHA_FULL}) ?
                            ALPHA_FULL : alpha_sum[ALPHA_W-1:0];
          window_end_seq <= item_next;
          marked_bytes   <= '0;
          total_bytes    <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_kind  <= kind_t'(request.kind);
      item_acked <= request.acked_seq;
      item_next  <= request.next_send_seq;
      item_mss   <= request.recv_mss;
      item_ece   <= request.ece_flag;
      item_wupd  <= request.window_update_flag;
      closed     <= 1'b0;
    end
    if (state == ST_COUNT) begin
      count   <= (count_raw == '0 && !item_wupd) ?
                 {{(SEQ_W-MSS_W){1'b0}}, item_mss} : count_raw;
      win_end <= !end_diff[SEQ_W-1];
    end
    if (state == ST_PREP) begin
      alpha_dec <= alpha_value - (alpha_value >> gain_shift);
    end
    if (state == ST_ALPHA) begin
      closed <= 1'b1;
    end
    if (load_out) begin
      res_alpha  <= alpha_value;
      res_closed <= closed;
    end
  end

  assign result.valid         = res_valid;
  assign result.alpha         = res_alpha;
  assign result.window_closed = res_closed;

endmodule
